### rtl/abs_pkg.sv
// types, codes and checksum function for the alternating bit sender
`timescale 1ns / 1ps

package abs_pkg;

  localparam int unsigned PAYLOAD_BYTES = 20;
  localparam int unsigned PAYLOAD_W     = 8 * PAYLOAD_BYTES;
  localparam int unsigned SUM_LANES     = 32;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned DATA_W        = 32;

  localparam logic [15:0] NO_ACK_BITS   = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30;

  localparam logic [0:0] REG_TIMEOUT_TICKS = 1'b0;

  typedef enum logic [1:0] {
    FN_MSG  = 2'd0,
    FN_PKT  = 2'd1,
    FN_TICK = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE0 = 2'd0,
    PH_WAIT0 = 2'd1,
    PH_IDLE1 = 2'd2,
    PH_WAIT1 = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        payload_low;
    logic [63:0]        payload_mid;
    logic [31:0]        payload_high;
    logic signed [15:0] pkt_seq;
    logic signed [15:0] pkt_ack;
    logic [15:0]        pkt_checksum;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic        msg_accepted;
    logic        ack_matched;
    logic        out_seq;
    logic [15:0] out_checksum;
    logic [63:0] out_payload_low;
    logic [63:0] out_payload_mid;
    logic [31:0] out_payload_high;
    logic [1:0]  phase;
  } out_item_t;

  // 16-bit sum of sign-extended bytes and seq (only when byte 0 nonzero) plus ack
  // bytes and seq are added as a balanced tree
  function automatic logic [15:0] abs_checksum(input logic [PAYLOAD_W-1:0] bytes,
                                               input logic [15:0] seq_bits,
                                               input logic [15:0] ack_bits);
    logic [15:0] lane [SUM_LANES];
    logic [15:0] sum;
    for (int i = 0; i < SUM_LANES; i++) begin
      lane[i] = '0;
    end
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      lane[i] = {{8{bytes[8*i+7]}}, bytes[8*i +: 8]};
    end
    lane[PAYLOAD_BYTES] = seq_bits;
    for (int w = SUM_LANES >> 1; w > 0; w = w >> 1) begin
      for (int i = 0; i < w; i++) begin
        lane[i] = lane[2*i] + lane[2*i+1];
      end
    end
    sum = ack_bits;
    if (bytes[7:0] != 8'd0) begin
      sum = sum + lane[0];
    end
    return sum;
  endfunction

endpackage

### rtl/abs_stream_if.sv
// valid/ready channel carrying one transaction payload
`timescale 1ns / 1ps

interface abs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/alternating_bit_sender.sv
// alternating bit protocol sender with internal retransmit timer
//
// req carries one event per transaction: func 0 is a message from above,
// func 1 a packet from the channel, func 2 one timer tick. every accepted
// transaction produces exactly one rsp transaction with flags, the packet
// to send (when send_valid is set) and the phase after the event.
// rsp becomes valid in the cycle after req acceptance; one transaction
// is taken every cycle unless rsp stalls, limited only by the single output register.
// req.ready stays high while the output register is empty or being drained,
// so a stalled receiver holds rsp and blocks req only while it stalls.
// timeout_ticks is written over the apb port at byte address 0 and should
// change only while no transaction is pending.
// reset returns to idle for sequence 0 with the timer stopped, empties the
// output register and sets timeout_ticks to 30. the saved payload is not
// cleared; it is always written before a retransmit reads it.
`timescale 1ns / 1ps

module alternating_bit_sender
  import abs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  abs_stream_if.sink          req,
  abs_stream_if.source        rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  phase_t               phase, phase_next;
  logic                 saved_seq, saved_seq_next;
  logic [15:0]          saved_checksum, saved_checksum_next;
  logic [PAYLOAD_W-1:0] saved_payload, saved_payload_next;
  logic [15:0]          tick_count, tick_count_next;
  logic                 timer_running, timer_running_next;
  logic [15:0]          timeout_ticks;
  logic                 out_valid;
  out_item_t            out_item, res;

  in_item_t             d;
  logic [PAYLOAD_W-1:0] in_bytes;
  logic                 accept;
  logic [1:0]           phase_inc;
  logic [16:0]          tick_inc;
  logic [15:0]          msg_checksum;
  logic [15:0]          pkt_sum;

  assign d         = req.data;
  assign in_bytes  = {d.payload_high, d.payload_mid, d.payload_low};
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  assign phase_inc    = phase + 2'd1;
  assign tick_inc     = {1'b0, tick_count} + 17'd1;
  assign msg_checksum = abs_checksum(in_bytes, {15'd0, phase[1]}, NO_ACK_BITS);
  assign pkt_sum      = abs_checksum(in_bytes, unsigned'(d.pkt_seq), unsigned'(d.pkt_ack));

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT_TICKS) begin
      prdata = {{(DATA_W-16){1'b0}}, timeout_ticks};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT_TICKS) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  // next state and result
  always_comb begin
    phase_next          = phase;
    saved_seq_next      = saved_seq;
    saved_checksum_next = saved_checksum;
    saved_payload_next  = saved_payload;
    tick_count_next     = tick_count;
    timer_running_next  = timer_running;
    res                 = '0;

    case (func_t'(d.func))
      FN_MSG: begin
        if (!phase[0]) begin
          saved_seq_next       = phase[1];
          saved_checksum_next  = msg_checksum;
          saved_payload_next   = in_bytes;
          tick_count_next      = '0;
          timer_running_next   = 1'b1;
          phase_next           = phase_t'(phase_inc);
          res.send_valid       = 1'b1;
          res.msg_accepted     = 1'b1;
          res.out_seq          = phase[1];
          res.out_checksum     = msg_checksum;
          res.out_payload_low  = d.payload_low;
          res.out_payload_mid  = d.payload_mid;
          res.out_payload_high = d.payload_high;
        end
      end
      FN_PKT: begin
        if (phase[0] && pkt_sum == d.pkt_checksum &&
            unsigned'(d.pkt_ack) == {15'd0, phase[1]}) begin
          timer_running_next = 1'b0;
          tick_count_next    = '0;
          res.ack_matched    = 1'b1;
          phase_next         = phase_t'(phase_inc);
        end
      end
      FN_TICK: begin
        if (timer_running) begin
          if (tick_inc >= {1'b0, timeout_ticks}) begin
            tick_count_next = '0;
            if (phase[0]) begin
              res.send_valid       = 1'b1;
              res.out_seq          = saved_seq;
              res.out_checksum     = saved_checksum;
              res.out_payload_low  = saved_payload[63:0];
              res.out_payload_mid  = saved_payload[127:64];
              res.out_payload_high = saved_payload[159:128];
            end else begin
              timer_running_next = 1'b0;
            end
          end else begin
            tick_count_next = tick_inc[15:0];
          end
        end
      end
      default: begin
      end
    endcase

    res.phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE0;
      saved_seq      <= 1'b0;
      saved_checksum <= '0;
      tick_count     <= '0;
      timer_running  <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      saved_seq      <= saved_seq_next;
      saved_checksum <= saved_checksum_next;
      tick_count     <= tick_count_next;
      timer_running  <= timer_running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      saved_payload <= saved_payload_next;
      out_item      <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
